// File: design/assert_macros.svh
// Assertion helpers shared by the design files.
// ASSERT_CHECK checks a whole property; ASSERT_IMPLY checks an overlapping implication.
// Both are clocked on the rising edge and are off while reset is asserted (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CHECK(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_CHECK(lbl, ck, rn, prop, msg)
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg)
`endif
`endif

// File: design/tss_pkg.sv
package tss_pkg;

	localparam int MAX_TERMS = 16;
	localparam int FRAC_BITS = 28;

	localparam int X_W     = 32;
	localparam int RES_W   = 48;
	localparam int MAG_W   = RES_W - 1;
	localparam int TC_W    = 4;
	localparam int KMAX_TOP = 2 * MAX_TERMS - 1;
	localparam int K_W     = $clog2(KMAX_TOP + 1);
	localparam int SUM_W   = MAG_W + K_W + 1;

	// Split of the term magnitude for the two partial products.
	localparam int A_LO_W  = 32;
	localparam int A_HI_W  = MAG_W - A_LO_W;
	localparam int PPL_W   = A_LO_W + X_W;
	localparam int PPH_W   = A_HI_W + X_W;
	localparam int PROD_W  = MAG_W + X_W;
	localparam int PDIV_W  = PROD_W - FRAC_BITS;

	// The dividend is divided by the term index in two halves.
	localparam int DIV_LO_W = 26;
	localparam int DIV_HI_W = PDIV_W - DIV_LO_W;
	localparam int DIV_Q_W  = DIV_LO_W;
	localparam int DIV_IN_W = DIV_LO_W + K_W;
	localparam int RECIP_W  = DIV_IN_W + 1;
	localparam int OVF_W    = PDIV_W - MAG_W;

	localparam logic [TC_W-1:0] TERM_COUNT_RST = TC_W'(10);

	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
	localparam logic [MAG_W-1:0] MAG_ONE =
		{{(MAG_W - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [PROD_W-1:0] PROD_RND =
		{{(PROD_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
	localparam logic signed [SUM_W-1:0] SUM_HI = $signed({{(SUM_W - MAG_W){1'b0}}, MAG_MAX});
	localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_HI - SUM_W'(1);

	// floor(2^31 / k) for every term index k; entry 0 is never used.
	localparam logic [RECIP_W-1:0] RECIP [0:KMAX_TOP] = '{
		32'd0,         32'd2147483648, 32'd1073741824, 32'd715827882,
		32'd536870912, 32'd429496729,  32'd357913941,  32'd306783378,
		32'd268435456, 32'd238609294,  32'd214748364,  32'd195225786,
		32'd178956970, 32'd165191049,  32'd153391689,  32'd143165576,
		32'd134217728, 32'd126322567,  32'd119304647,  32'd113025455,
		32'd107374182, 32'd102261126,  32'd97612893,   32'd93368854,
		32'd89478485,  32'd85899345,   32'd82595524,   32'd79536431,
		32'd76695844,  32'd74051160,   32'd71582788,   32'd69273666
	};

	typedef enum logic [1:0] {
		FN_SIN  = 2'd0,
		FN_COS  = 2'd1,
		FN_EXP  = 2'd2,
		FN_NONE = 2'd3
	} func_t;

	// One request as it travels down the term chain.
	typedef struct packed {
		func_t                   func;
		logic                    xneg;
		logic [X_W-1:0]          ux;
		logic [K_W-1:0]          kmax;
		logic signed [SUM_W-1:0] sum;
		logic                    ovf;
		logic [MAG_W-1:0]        mag;
	} item_t;

	// Adds or subtracts the current magnitude as series term idx, if this function uses it and idx <= kmax.
	function automatic item_t acc_term(item_t it, logic [K_W-1:0] idx);
		logic                    use_t;
		logic                    neg_t;
		logic signed [SUM_W-1:0] addend;
		item_t                   r;
		r = it;
		case (it.func)
			FN_EXP:  use_t = 1'b1;
			FN_SIN:  use_t = idx[0];
			default: use_t = !idx[0];
		endcase
		neg_t  = (it.xneg & idx[0]) ^ ((it.func != FN_EXP) & idx[1]);
		addend = $signed({{(SUM_W - MAG_W){1'b0}}, it.mag});
		if (use_t && (idx <= it.kmax)) begin
			r.sum = neg_t ? (it.sum - addend) : (it.sum + addend);
		end
		return r;
	endfunction

endpackage

// File: design/taylor_series_sin_cos_exp_unit.sv
`include "assert_macros.svh"

// Truncated Maclaurin series for sine, cosine and e^x on a Q3.28 argument, giving a
// saturated Q19.28 result and a saturation flag. The unit is a fully pipelined chain
// of 31 identical term sections, one per series index k, each four registers deep, so
// one request can enter on every clock while not stalled, and a result passes through
// one entry stage, 31 x 4 term stages, one final accumulate stage and the output
// register. The depth is fixed by the term sections: each one multiplies the previous
// term by |x| as two partial products, rounds, and divides by k in two halves with a
// reciprocal multiply. The term_count register (reset value 10, values above 15 are
// limited to 15) is sampled when a request enters, so it should be written only while
// the unit is idle. A stalled output freezes the whole chain only once the final stage
// also holds a result; until then requests keep entering and bubbles are squeezed out.
module taylor_series_sin_cos_exp_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tss_pkg::TC_W-1:0]          cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        func,
	input  logic signed [tss_pkg::X_W-1:0]    x,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [tss_pkg::RES_W-1:0]  result,
	output logic                              saturated
);

	localparam int NSEC = tss_pkg::KMAX_TOP;

	logic [tss_pkg::TC_W-1:0]   term_count_q;
	logic                       adv;

	logic                       ent_valid_s1;
	tss_pkg::item_t             ent_item_s1;
	tss_pkg::item_t             ent_n;
	logic [tss_pkg::K_W-1:0]    nl;

	logic                       sec_valid [0:NSEC];
	tss_pkg::item_t             sec_item  [0:NSEC];

	logic                       fin_valid_s2;
	tss_pkg::item_t             fin_item_s2;

	logic                       out_valid_q;
	logic signed [tss_pkg::RES_W-1:0] result_q;
	logic                       saturated_q;
	logic signed [tss_pkg::RES_W-1:0] res_n;
	logic                       sat_n;

	// The user should write the configuration register only while the unit is idle; the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= tss_pkg::TERM_COUNT_RST;
		end else if (cfg_we) begin
			term_count_q <= cfg_wdata;
		end
	end

	// The chain advances unless the final stage has a result that the full, stalled
	// output register cannot take.
	assign adv      = !(fin_valid_s2 && out_valid_q && out_stall);
	assign in_stall = !adv;

	// Entry stage: take |x|, its sign, and the highest series index for this function.
	always_comb begin
		if (tss_pkg::K_W'(term_count_q) > tss_pkg::K_W'(tss_pkg::MAX_TERMS - 1)) begin
			nl = tss_pkg::K_W'(tss_pkg::MAX_TERMS - 1);
		end else begin
			nl = tss_pkg::K_W'(term_count_q);
		end
		ent_n.func = tss_pkg::func_t'(func);
		ent_n.xneg = x[tss_pkg::X_W-1];
		ent_n.ux   = x[tss_pkg::X_W-1] ? (~$unsigned(x) + tss_pkg::X_W'(1)) : $unsigned(x);
		case (tss_pkg::func_t'(func))
			tss_pkg::FN_SIN: ent_n.kmax = tss_pkg::K_W'((nl << 1) | tss_pkg::K_W'(1));
			tss_pkg::FN_COS: ent_n.kmax = tss_pkg::K_W'(nl << 1);
			default:         ent_n.kmax = nl;
		endcase
		ent_n.sum  = '0;
		ent_n.ovf  = 1'b0;
		ent_n.mag  = tss_pkg::MAG_ONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_s1 <= 1'b0;
		end else if (adv) begin
			ent_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_item_s1 <= ent_n;
		end
	end

	assign sec_valid[0] = ent_valid_s1;
	assign sec_item[0]  = ent_item_s1;

	// Section k builds term k and folds term k-1 into the running sum.
	for (genvar i = 1; i <= NSEC; i++) begin : g_sec
		tss_term u_term (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.k         (tss_pkg::K_W'(i)),
			.in_valid  (sec_valid[i-1]),
			.in_item   (sec_item[i-1]),
			.out_valid (sec_valid[i]),
			.out_item  (sec_item[i])
		);
	end

	// Final stage folds in the last term.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_s2 <= 1'b0;
		end else if (adv) begin
			fin_valid_s2 <= sec_valid[NSEC];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fin_item_s2 <= tss_pkg::acc_term(sec_item[NSEC], tss_pkg::K_W'(NSEC));
		end
	end

	// Clamp the sum to the result range; the unused selector gives zero.
	always_comb begin
		if (fin_item_s2.func == tss_pkg::FN_NONE) begin
			res_n = '0;
			sat_n = 1'b0;
		end else if (fin_item_s2.sum > tss_pkg::SUM_HI) begin
			res_n = tss_pkg::SUM_HI[tss_pkg::RES_W-1:0];
			sat_n = 1'b1;
		end else if (fin_item_s2.sum < tss_pkg::SUM_LO) begin
			res_n = tss_pkg::SUM_LO[tss_pkg::RES_W-1:0];
			sat_n = 1'b1;
		end else begin
			res_n = fin_item_s2.sum[tss_pkg::RES_W-1:0];
			sat_n = fin_item_s2.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= fin_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			result_q    <= res_n;
			saturated_q <= sat_n;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign saturated = saturated_q;

	`ASSERT_IMPLY(a_stall_needs_full_out, clk, arst_n, in_stall, out_valid_q && out_stall, "input stalled while output can drain")
	`ASSERT_IMPLY(a_drain_frees_input, clk, arst_n, !out_stall, !in_stall, "input stalled with output not stalled")
	`ASSERT_CHECK(a_out_hold, clk, arst_n, out_valid_q && out_stall |=> out_valid_q && $stable(result_q) && $stable(saturated_q), "stalled result changed")

endmodule

// File: design/tss_divstep.sv
// Divides v by the small constant k: reciprocal multiply, then one correction.
module tss_divstep (
	input  logic [tss_pkg::DIV_IN_W-1:0] v,
	input  logic [tss_pkg::K_W-1:0]      k,
	output logic [tss_pkg::DIV_Q_W-1:0]  q,
	output logic [tss_pkg::K_W-1:0]      r
);

	localparam int PW = tss_pkg::DIV_IN_W + tss_pkg::RECIP_W;

	logic [PW-1:0]                   prod;
	logic [tss_pkg::DIV_Q_W-1:0]     q0;
	logic [tss_pkg::DIV_IN_W-1:0]    r0;

	always_comb begin
		prod = PW'(v) * PW'(tss_pkg::RECIP[k]);
		q0   = prod[tss_pkg::DIV_IN_W +: tss_pkg::DIV_Q_W];
		// The estimate is low by at most one.
		r0   = v - (tss_pkg::DIV_IN_W'(q0) * tss_pkg::DIV_IN_W'(k));
		if (r0 >= tss_pkg::DIV_IN_W'(k)) begin
			q = q0 + tss_pkg::DIV_Q_W'(1);
			r = tss_pkg::K_W'(r0 - tss_pkg::DIV_IN_W'(k));
		end else begin
			q = q0;
			r = tss_pkg::K_W'(r0);
		end
	end

endmodule

// File: design/tss_term.sv
`include "assert_macros.svh"

// One series step: adds term k-1 to the sum and builds term k = round(round(a*|x|)/k).
module tss_term (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [tss_pkg::K_W-1:0] k,
	input  logic                  in_valid,
	input  tss_pkg::item_t        in_item,
	output logic                  out_valid,
	output tss_pkg::item_t        out_item
);

	logic                              v_s1, v_s2, v_s3, v_s4;
	tss_pkg::item_t                    it_s1, it_s2, it_s3, it_s4;
	logic [tss_pkg::PPL_W-1:0]         ppl_s1;
	logic [tss_pkg::PPH_W-1:0]         pph_s1;
	logic [tss_pkg::PDIV_W-1:0]        pd_s2;
	logic                              tovf_s2, tovf_s3;
	logic [tss_pkg::DIV_HI_W-1:0]      qh_s3;
	logic [tss_pkg::K_W-1:0]           r1_s3;
	logic [tss_pkg::DIV_LO_W-1:0]      lo_s3;

	logic [tss_pkg::PROD_W-1:0]        full;
	logic [tss_pkg::PDIV_W-1:0]        pd_n;
	logic                              tovf_n;
	logic [tss_pkg::DIV_Q_W-1:0]       qh_n, ql_n;
	logic [tss_pkg::K_W-1:0]           r1_n, r2_n;
	logic [tss_pkg::PDIV_W-1:0]        qfull;
	tss_pkg::item_t                    it_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: partial products of a*|x| and the sum update for term k-1.
	always_ff @(posedge clk) begin
		if (en) begin
			it_s1  <= tss_pkg::acc_term(in_item, tss_pkg::K_W'(k - tss_pkg::K_W'(1)));
			ppl_s1 <= tss_pkg::PPL_W'(in_item.mag[tss_pkg::A_LO_W-1:0]) *
				tss_pkg::PPL_W'(in_item.ux);
			pph_s1 <= tss_pkg::PPH_W'(in_item.mag[tss_pkg::MAG_W-1:tss_pkg::A_LO_W]) *
				tss_pkg::PPH_W'(in_item.ux);
		end
	end

	// Stage 2: combine, round off the fraction, add k/2 and detect overflow.
	always_comb begin
		full = (tss_pkg::PROD_W'(pph_s1) << tss_pkg::A_LO_W) +
			tss_pkg::PROD_W'(ppl_s1) + tss_pkg::PROD_RND;
		pd_n = full[tss_pkg::PROD_W-1:tss_pkg::FRAC_BITS] +
			tss_pkg::PDIV_W'(k >> 1);
		tovf_n = (tss_pkg::K_W + tss_pkg::OVF_W)'(pd_n[tss_pkg::PDIV_W-1:tss_pkg::MAG_W]) >=
			(tss_pkg::K_W + tss_pkg::OVF_W)'(k);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s2   <= it_s1;
			pd_s2   <= pd_n;
			tovf_s2 <= tovf_n;
		end
	end

	// Stage 3: upper half of the division.
	tss_divstep u_div_hi (
		.v (tss_pkg::DIV_IN_W'(pd_s2[tss_pkg::PDIV_W-1:tss_pkg::DIV_LO_W])),
		.k (k),
		.q (qh_n),
		.r (r1_n)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			it_s3   <= it_s2;
			qh_s3   <= qh_n[tss_pkg::DIV_HI_W-1:0];
			r1_s3   <= r1_n;
			lo_s3   <= pd_s2[tss_pkg::DIV_LO_W-1:0];
			tovf_s3 <= tovf_s2;
		end
	end

	// Stage 4: lower half of the division and the clamp.
	tss_divstep u_div_lo (
		.v ({r1_s3, lo_s3}),
		.k (k),
		.q (ql_n),
		.r (r2_n)
	);

	assign qfull = {qh_s3, ql_n};

	always_comb begin
		it_n     = it_s3;
		it_n.mag = tovf_s3 ? tss_pkg::MAG_MAX : qfull[tss_pkg::MAG_W-1:0];
		it_n.ovf = it_s3.ovf | (tovf_s3 && (k <= it_s3.kmax) && (r2_n < k));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s4 <= it_n;
		end
	end

	assign out_valid = v_s4;
	assign out_item  = it_s4;

	`ASSERT_IMPLY(a_rem_below_k, clk, arst_n, v_s3, r1_s3 < k, "upper remainder not below k")
	`ASSERT_IMPLY(a_rem_lo_below_k, clk, arst_n, v_s3, r2_n < k, "lower remainder not below k")
	`ASSERT_CHECK(a_ovf_sticky, clk, arst_n, en && v_s3 && it_s3.ovf |=> it_s4.ovf, "overflow flag lost")

endmodule
